FILE: hw/rtl/tbc_pkg.sv
// ----------------------------------------------------------------------------
// Barycentric weights package
// Shared payload types, widths and constants for the barycentric core.
// ----------------------------------------------------------------------------
package tbc_pkg;

	localparam int CoordW = 16;
	localparam int EdgeW  = 35;
	localparam int NumW   = EdgeW + 16;
	localparam int QuoW   = NumW;
	localparam int WeightW = 32;
	localparam int AddrW  = 5;

	localparam logic [AddrW-1:0] RegAx = 5'd0;
	localparam logic [AddrW-1:0] RegAy = 5'd4;
	localparam logic [AddrW-1:0] RegBx = 5'd8;
	localparam logic [AddrW-1:0] RegBy = 5'd12;
	localparam logic [AddrW-1:0] RegCx = 5'd16;
	localparam logic [AddrW-1:0] RegCy = 5'd20;

	typedef struct packed {
		logic signed [CoordW-1:0] point_x;
		logic signed [CoordW-1:0] point_y;
	} req_t;

	typedef struct packed {
		logic signed [WeightW-1:0] weight_alpha;
		logic signed [WeightW-1:0] weight_beta;
		logic signed [WeightW-1:0] weight_gamma;
		logic                      degenerate;
	} rsp_t;

	// Data handed from one divider cell to the next
	typedef struct packed {
		logic                   vld;
		logic                   g_neg;
		logic                   b_neg;
		logic                   degen;
		logic [NumW-1:0]        g_rem;
		logic [NumW-1:0]        b_rem;
		logic [QuoW-1:0]        g_quo;
		logic [QuoW-1:0]        b_quo;
	} cell_t;

	// Saturate a wide signed value to 32 bits
	function automatic logic signed [WeightW-1:0] sat32(input logic signed [QuoW+1:0] v);
		logic signed [QuoW+1:0] hi;
		logic signed [QuoW+1:0] lo;
		hi = (QuoW+2)'(64'sd2147483647);
		lo = -(QuoW+2)'(64'sd2147483648);
		if (v > hi)
			return 32'h7fffffff;
		else if (v < lo)
			return 32'h80000000;
		else
			return v[WeightW-1:0];
	endfunction

endpackage

FILE: hw/rtl/triangle_barycentric_coords_core.sv
// Pipeline: three front stages, one divider cell per each of the 51 quotient
// bits, one output register.
// Throughput: one request per cycle; a stall on the output freezes the whole chain.
// arst_n clears all valid bits and sets every vertex register to zero.
// ----------------------------------------------------------------------------
// Barycentric coordinates core
// Edge functions by pipelined multipliers, then a chain of restoring divider cells.
// ----------------------------------------------------------------------------
module triangle_barycentric_coords_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tbc_pkg::AddrW-1:0]     paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  tbc_pkg::req_t                 in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output tbc_pkg::rsp_t                 out_data
);

	localparam int EW = tbc_pkg::EdgeW;
	localparam int NW = tbc_pkg::NumW;
	localparam int QW = tbc_pkg::QuoW;

	logic signed [15:0] ax_q, ay_q, bx_q, by_q, cx_q, cy_q;
	logic adv;

	assign pready = 1'b1;
	assign adv = !(out_valid && out_stall);
	assign in_stall = !adv;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ax_q <= '0; ay_q <= '0; bx_q <= '0; by_q <= '0; cx_q <= '0; cy_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr)
				tbc_pkg::RegAx: ax_q <= pwdata[15:0];
				tbc_pkg::RegAy: ay_q <= pwdata[15:0];
				tbc_pkg::RegBx: bx_q <= pwdata[15:0];
				tbc_pkg::RegBy: by_q <= pwdata[15:0];
				tbc_pkg::RegCx: cx_q <= pwdata[15:0];
				tbc_pkg::RegCy: cy_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Register reads
	always_comb begin
		unique case (paddr)
			tbc_pkg::RegAx: prdata = {{16{ax_q[15]}}, ax_q};
			tbc_pkg::RegAy: prdata = {{16{ay_q[15]}}, ay_q};
			tbc_pkg::RegBx: prdata = {{16{bx_q[15]}}, bx_q};
			tbc_pkg::RegBy: prdata = {{16{by_q[15]}}, by_q};
			tbc_pkg::RegCx: prdata = {{16{cx_q[15]}}, cx_q};
			tbc_pkg::RegCy: prdata = {{16{cy_q[15]}}, cy_q};
			default:        prdata = '0;
		endcase
	end

	// Coefficients and denominators; user keeps them static while busy (unenforced)
	logic signed [16:0] gcx, gcy, bcx, bcy;
	logic signed [EW-1:0] gk, bk, g_den, b_den;
	logic signed [EW-1:0] g_den_r, b_den_r;
	logic [EW-1:0] g_den_abs, b_den_abs;
	always_comb begin
		gcx = 17'(ay_q) - 17'(by_q);
		gcy = 17'(bx_q) - 17'(ax_q);
		bcx = 17'(ay_q) - 17'(cy_q);
		bcy = 17'(cx_q) - 17'(ax_q);
	end

	// Denominators and constant terms, registered without enable or reset
	always_ff @(posedge clk) begin
		gk <= EW'(ax_q * by_q) - EW'(bx_q * ay_q);
		bk <= EW'(ax_q * cy_q) - EW'(cx_q * ay_q);
		g_den_r <= EW'(gcx * cx_q) + EW'(gcy * cy_q);
		b_den_r <= EW'(bcx * bx_q) + EW'(bcy * by_q);
	end
	assign g_den = g_den_r + gk;
	assign b_den = b_den_r + bk;
	assign g_den_abs = g_den[EW-1] ? EW'(-g_den) : g_den;
	assign b_den_abs = b_den[EW-1] ? EW'(-b_den) : b_den;

	// Stage 1: products with the point
	logic vld_s1, vld_s2;
	logic signed [EW-1:0] gp0_s1, gp1_s1, bp0_s1, bp1_s1;
	logic signed [EW-1:0] gn_s2, bn_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0; vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid; vld_s2 <= vld_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			gp0_s1 <= EW'(gcx * in_data.point_x);
			gp1_s1 <= EW'(gcy * in_data.point_y);
			bp0_s1 <= EW'(bcx * in_data.point_x);
			bp1_s1 <= EW'(bcy * in_data.point_y);
			gn_s2 <= gp0_s1 + gp1_s1 + gk;
			bn_s2 <= bp0_s1 + bp1_s1 + bk;
		end
	end

	// Stage 3: signs, magnitudes scaled by 2^16
	tbc_pkg::cell_t c_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_s3 <= '0;
		end else if (adv) begin
			c_s3.vld <= vld_s2;
			c_s3.g_neg <= gn_s2[EW-1] ^ g_den[EW-1];
			c_s3.b_neg <= bn_s2[EW-1] ^ b_den[EW-1];
			c_s3.degen <= (g_den == '0) || (b_den == '0);
			c_s3.g_rem <= {(gn_s2[EW-1] ? EW'(-gn_s2) : gn_s2), 16'h0};
			c_s3.b_rem <= {(bn_s2[EW-1] ? EW'(-bn_s2) : bn_s2), 16'h0};
			c_s3.g_quo <= '0;
			c_s3.b_quo <= '0;
		end
	end

	// Chain of divider cells, most significant quotient bit first
	tbc_pkg::cell_t chain [QW+1];
	assign chain[0] = c_s3;
	for (genvar i = 0; i < QW; i++) begin : g_cell
		tbc_div_cell #(.Bit(QW-1-i)) u_cell (
			.clk(clk), .arst_n(arst_n), .adv(adv),
			.g_den(g_den_abs), .b_den(b_den_abs),
			.cin(chain[i]), .cout(chain[i+1])
		);
	end

	// Output stage: signs, alpha, saturation, zero weights when degenerate
	tbc_pkg::cell_t last;
	logic signed [QW+1:0] gq, bq, aq;
	assign last = chain[QW];
	always_comb begin
		gq = last.g_neg ? -$signed({2'b00, last.g_quo}) : $signed({2'b00, last.g_quo});
		bq = last.b_neg ? -$signed({2'b00, last.b_quo}) : $signed({2'b00, last.b_quo});
		aq = (QW+2)'(65536) - gq - bq;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (adv)
			out_valid <= last.vld;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			out_data.degenerate <= last.degen;
			out_data.weight_alpha <= last.degen ? '0 : tbc_pkg::sat32(aq);
			out_data.weight_beta  <= last.degen ? '0 : tbc_pkg::sat32(bq);
			out_data.weight_gamma <= last.degen ? '0 : tbc_pkg::sat32(gq);
		end
	end

	logic unused_ok;
	assign unused_ok = ^{pwdata[31:16], NW};

endmodule

FILE: hw/rtl/tbc_div_cell.sv
// ----------------------------------------------------------------------------
// Divider cell
// One restoring division step for beta and gamma per cycle unless stalled.
// ----------------------------------------------------------------------------
module tbc_div_cell #(
	parameter int Bit = 0
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           adv,
	input  logic [tbc_pkg::EdgeW-1:0]      g_den,
	input  logic [tbc_pkg::EdgeW-1:0]      b_den,
	input  tbc_pkg::cell_t                 cin,
	output tbc_pkg::cell_t                 cout
);

	localparam int W  = tbc_pkg::NumW;
	localparam int EW = tbc_pkg::EdgeW;

	logic [W+EW:0] g_full;
	logic [W+EW:0] b_full;
	logic g_big;
	logic b_big;
	logic [W:0] g_try;
	logic [W:0] b_try;
	logic [W:0] g_shd;
	logic [W:0] b_shd;
	tbc_pkg::cell_t nxt;

	// Trial subtract of the shifted divisor from each remainder; a divisor
	// shifted past the remainder width can never fit
	always_comb begin
		g_full = (W+EW+1)'(g_den) << Bit;
		b_full = (W+EW+1)'(b_den) << Bit;
		g_big = |g_full[W+EW:W];
		b_big = |b_full[W+EW:W];
		g_shd = g_full[W:0];
		b_shd = b_full[W:0];
		g_try = {1'b0, cin.g_rem} - g_shd;
		b_try = {1'b0, cin.b_rem} - b_shd;
		nxt = cin;
		if (!g_try[W] && !g_big) begin
			nxt.g_rem = g_try[W-1:0];
			nxt.g_quo[Bit] = 1'b1;
		end
		if (!b_try[W] && !b_big) begin
			nxt.b_rem = b_try[W-1:0];
			nxt.b_quo[Bit] = 1'b1;
		end
	end

	// Advance the request to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cout <= '0;
		else if (adv)
			cout <= nxt;
	end

endmodule

FILE: hw/rtl/tbc_checker.sv
// ----------------------------------------------------------------------------
// Barycentric core port checker
// Port-level properties of the request and result channels.
// ----------------------------------------------------------------------------
module tbc_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_stall,
	input logic          out_valid,
	input logic          out_stall,
	input tbc_pkg::rsp_t out_data
);

	// Hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// Input stall follows a blocked output
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall mismatch");

	// Degenerate results carry zero weights
	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.degenerate |-> out_data.weight_alpha == '0 &&
		out_data.weight_beta == '0 && out_data.weight_gamma == '0)
		else $error("degenerate weights not zero");

endmodule

bind triangle_barycentric_coords_core tbc_checker u_tbc_checker (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
